// ===== sv/gauge_needle_slew_limiter_assert.svh =====
// Assertion macros shared by the gauge needle checker.
`ifndef GAUGE_NEEDLE_SLEW_LIMITER_ASSERT_SVH
`define GAUGE_NEEDLE_SLEW_LIMITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GNSL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GNSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/gnsl_pkg.sv =====
// Shared types and constants for the gauge needle slew limiter.
package gnsl_pkg;

  localparam int unsigned ANGLE_W     = 16;
  localparam int unsigned CFG_ANGLE_W = 10;
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned DIFF_W      = 17;  // difference of two 16-bit values
  localparam int unsigned SPAN_W      = 11;  // difference of two 10-bit angles
  localparam int unsigned PROD_W      = DIFF_W + SPAN_W;
  localparam int unsigned NUM_W       = 26;  // |product| < 2^26 for all inputs
  localparam int unsigned DEN_W       = 16;  // |denominator| <= 65535
  localparam int unsigned DIV_CNT_W   = $clog2(NUM_W + 1);
  localparam int unsigned CFG_ADDR_W  = 4;

  localparam logic signed [ANGLE_W-1:0] ANGLE_CEILING = 16'sd359;
  localparam int unsigned               PERCENT_FULL  = 100;
  localparam logic [COUNT_W-1:0]        COUNT_MAX     = 8'hFF;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_VALUE   = 2'd1,
    KIND_PERCENT = 2'd2,
    KIND_ANGLE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_MIN_ANGLE = 2'd0,
    REG_MAX_ANGLE = 2'd1,
    REG_MIN_VALUE = 2'd2,
    REG_MAX_VALUE = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== sv/gnsl_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module gnsl_div
  import gnsl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0]     rem_q, rem_d;
  logic [NUM_W-1:0]     quo_q, quo_d;
  logic [DEN_W-1:0]     den_q, den_d;

  logic [DEN_W:0]       rem_sh;
  logic [DEN_W+1:0]     diff;
  logic                 fit;

  // shared compare/subtract unit
  always_comb begin
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    fit    = ~diff[DEN_W+1];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(NUM_W);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fit};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      den_q  <= den_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== sv/gauge_needle_slew_limiter.sv =====
// Gauge needle positioner: range map to a target angle, slew-limited stepping.
//
// Input channel (in_valid_i / in_stall_o, kind_i, operand_i): one item per
// transfer. A tick (one per millisecond) may move the needle one step of
// STEP_DEGREES toward the target once more than STEP_INTERVAL_MS ticks have
// passed since the last step. Set angle, set percent and set value commands
// load a new target, clamped above at 359 degrees.
// Output channel (out_valid_o / out_stall_i): one transfer per input item with
// the needle angle after the item, an adjusting flag and a stepped flag.
// Ticks, set angle and set value on an empty value range go from the accepting
// edge through ST_EMIT into the output register. Set value and set percent go
// through ST_MUL (multiply), ST_START (divider load), ST_DIV (divider
// iterations, one quotient bit per cycle, then quotient load) and ST_EMIT
// (output load). One item is in work at a time; in_stall_o is high from the
// accepting edge until the result is loaded.
// The result sits in an output register, so a new item is taken while the
// previous result waits; a held result stalls only the final load.
// Reset (rst_ni, asynchronous, active low) puts needle, target and the tick
// counter at zero and the range registers at their defaults (angles 0..359,
// values 0..0). The user must write the registers over the APB port only while idle; the block does not enforce it.
module gauge_needle_slew_limiter
  import gnsl_pkg::*;
#(
  parameter int unsigned STEP_INTERVAL_MS = 5,
  parameter int unsigned STEP_DEGREES     = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic signed [VALUE_W-1:0]   operand_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [ANGLE_W-1:0]   needle_angle_o,
  output logic                        adjusting_o,
  output logic                        stepped_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [CFG_ADDR_W-1:0]       paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_EMIT
  } state_e;

  function automatic logic signed [ANGLE_W-1:0] clamp_angle(
    input logic signed [ANGLE_W-1:0] a
  );
    return (a > ANGLE_CEILING) ? ANGLE_CEILING : a;
  endfunction

  state_e state_q, state_d;

  // range registers
  logic signed [CFG_ANGLE_W-1:0] min_angle_q, min_angle_d;
  logic signed [CFG_ANGLE_W-1:0] max_angle_q, max_angle_d;
  logic signed [VALUE_W-1:0]     min_value_q, min_value_d;
  logic signed [VALUE_W-1:0]     max_value_q, max_value_d;

  // needle state
  logic signed [ANGLE_W-1:0]     cur_q, cur_d;
  logic signed [ANGLE_W-1:0]     tgt_q, tgt_d;
  logic [COUNT_W-1:0]            ms_q, ms_d;
  logic                          stepped_q, stepped_d;

  // range map operands
  logic signed [DIFF_W-1:0]      numa_q, numa_d;
  logic signed [DIFF_W-1:0]      den_q, den_d;
  logic signed [SPAN_W-1:0]      span_q, span_d;
  logic signed [PROD_W-1:0]      prod_q, prod_d;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic signed [ANGLE_W-1:0]     out_angle_q, out_angle_d;
  logic                          out_adj_q, out_adj_d;
  logic                          out_step_q, out_step_d;

  div_req_t                      div_req;
  div_rsp_t                      div_rsp;

  logic                          in_xfer;
  logic                          cfg_wr;
  kind_e                         kind;
  logic [COUNT_W-1:0]            ms_inc;
  logic                          do_step;
  logic signed [ANGLE_W:0]       cur_x, tgt_x, up, dn;
  logic signed [ANGLE_W-1:0]     step_angle;
  logic signed [ANGLE_W-1:0]     base_angle;
  logic signed [DIFF_W-1:0]      x_val, den_val;
  logic [PROD_W-1:0]             prod_mag;
  logic [DIFF_W-1:0]             den_mag;
  logic                          q_neg;
  logic signed [ANGLE_W-1:0]     q_lo, q_signed;
  logic                          out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign kind       = kind_e'(kind_i);
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign pready     = 1'b1;

  // register readback, sign extended
  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_MIN_ANGLE: prdata = {{(32-CFG_ANGLE_W){min_angle_q[CFG_ANGLE_W-1]}}, min_angle_q};
      REG_MAX_ANGLE: prdata = {{(32-CFG_ANGLE_W){max_angle_q[CFG_ANGLE_W-1]}}, max_angle_q};
      REG_MIN_VALUE: prdata = {{(32-VALUE_W){min_value_q[VALUE_W-1]}}, min_value_q};
      REG_MAX_VALUE: prdata = {{(32-VALUE_W){max_value_q[VALUE_W-1]}}, max_value_q};
      default:       prdata = '0;
    endcase
  end

  // tick: saturating ms counter and one clamped step toward the target
  always_comb begin
    ms_inc  = (ms_q != COUNT_MAX) ? ms_q + COUNT_W'(1) : ms_q;
    do_step = (cur_q != tgt_q) && (ms_inc > COUNT_W'(STEP_INTERVAL_MS));
    cur_x   = $signed({cur_q[ANGLE_W-1], cur_q});
    tgt_x   = $signed({tgt_q[ANGLE_W-1], tgt_q});
    up      = cur_x + $signed((ANGLE_W+1)'(STEP_DEGREES));
    dn      = cur_x - $signed((ANGLE_W+1)'(STEP_DEGREES));
    if (cur_q < tgt_q) begin
      step_angle = (up >= tgt_x) ? tgt_q : up[ANGLE_W-1:0];
    end else begin
      step_angle = (dn <= tgt_x) ? tgt_q : dn[ANGLE_W-1:0];
    end
  end

  // range map setup
  always_comb begin
    base_angle = ANGLE_W'(min_angle_q);
    if (kind == KIND_VALUE) begin
      x_val   = DIFF_W'(operand_i) - DIFF_W'(min_value_q);
      den_val = DIFF_W'(max_value_q) - DIFF_W'(min_value_q);
    end else begin
      x_val   = $signed({{(DIFF_W-8){1'b0}}, operand_i[7:0]});
      den_val = $signed(DIFF_W'(PERCENT_FULL));
    end
  end

  // sign and magnitude for the divider; quotient truncates toward zero
  always_comb begin
    prod_mag = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
    den_mag  = den_q[DIFF_W-1]  ? DIFF_W'(-den_q)  : DIFF_W'(den_q);
    q_neg    = prod_q[PROD_W-1] ^ den_q[DIFF_W-1];
    q_lo     = $signed(div_rsp.quotient[ANGLE_W-1:0]);
    q_signed = q_neg ? -q_lo : q_lo;
  end

  always_comb begin
    div_req.start    = (state_q == ST_START);
    div_req.dividend = prod_mag[NUM_W-1:0];
    div_req.divisor  = den_mag[DEN_W-1:0];
  end

  gnsl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    min_angle_d = min_angle_q;
    max_angle_d = max_angle_q;
    min_value_d = min_value_q;
    max_value_d = max_value_q;
    cur_d       = cur_q;
    tgt_d       = tgt_q;
    ms_d        = ms_q;
    stepped_d   = stepped_q;
    numa_d      = numa_q;
    den_d       = den_q;
    span_d      = span_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_angle_d = out_angle_q;
    out_adj_d   = out_adj_q;
    out_step_d  = out_step_q;

    if (cfg_wr) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_MIN_ANGLE: min_angle_d = pwdata[CFG_ANGLE_W-1:0];
        REG_MAX_ANGLE: max_angle_d = pwdata[CFG_ANGLE_W-1:0];
        REG_MIN_VALUE: min_value_d = pwdata[VALUE_W-1:0];
        REG_MAX_VALUE: max_value_d = pwdata[VALUE_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          stepped_d = 1'b0;
          state_d   = ST_EMIT;
          case (kind)
            KIND_TICK: begin
              if (do_step) begin
                cur_d     = step_angle;
                ms_d      = '0;
                stepped_d = 1'b1;
              end else begin
                ms_d = ms_inc;
              end
            end
            KIND_ANGLE: begin
              tgt_d = clamp_angle(operand_i);
            end
            default: begin
              numa_d = x_val;
              den_d  = den_val;
              span_d = SPAN_W'(max_angle_q) - SPAN_W'(min_angle_q);
              if (den_val == '0) begin
                tgt_d = clamp_angle(base_angle);
              end else begin
                state_d = ST_MUL;
              end
            end
          endcase
        end
      end
      ST_MUL: begin
        prod_d  = PROD_W'(numa_q) * PROD_W'(span_q);
        state_d = ST_START;
      end
      ST_START: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          // only the low 16 bits survive the wrap
          tgt_d   = clamp_angle(q_signed + base_angle);
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_angle_d = cur_q;
          out_adj_d   = (cur_q != tgt_q);
          out_step_d  = stepped_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      min_angle_q <= '0;
      max_angle_q <= CFG_ANGLE_W'(ANGLE_CEILING);
      min_value_q <= '0;
      max_value_q <= '0;
      cur_q       <= '0;
      tgt_q       <= '0;
      ms_q        <= '0;
      stepped_q   <= 1'b0;
      numa_q      <= '0;
      den_q       <= '0;
      span_q      <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_angle_q <= '0;
      out_adj_q   <= 1'b0;
      out_step_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      min_angle_q <= min_angle_d;
      max_angle_q <= max_angle_d;
      min_value_q <= min_value_d;
      max_value_q <= max_value_d;
      cur_q       <= cur_d;
      tgt_q       <= tgt_d;
      ms_q        <= ms_d;
      stepped_q   <= stepped_d;
      numa_q      <= numa_d;
      den_q       <= den_d;
      span_q      <= span_d;
      prod_q      <= prod_d;
      out_valid_q <= out_valid_d;
      out_angle_q <= out_angle_d;
      out_adj_q   <= out_adj_d;
      out_step_q  <= out_step_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign needle_angle_o = out_angle_q;
  assign adjusting_o    = out_adj_q;
  assign stepped_o      = out_step_q;

endmodule

// ===== sv/gnsl_checker.sv =====
// Port-level checker for the gauge needle slew limiter, with its bind.
`include "gauge_needle_slew_limiter_assert.svh"

module gnsl_checker
  import gnsl_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic signed [ANGLE_W-1:0] needle_angle_o,
  input logic                      adjusting_o,
  input logic                      stepped_o
);

  // held result stays put
  `GNSL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(needle_angle_o) && $stable(adjusting_o) && $stable(stepped_o), "stalled result changed")

  // an accepted item keeps the block busy for at least the next cycle
  `GNSL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "not busy after accept")

  // a new result only follows work in progress
  `GNSL_ASSERT_SAME(a_result_after_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result without work")

  // needle never passes the angle ceiling
  `GNSL_ASSERT_SAME(a_angle_ceiling, clk_i, rst_ni, out_valid_o, needle_angle_o <= ANGLE_CEILING, "needle above ceiling")

endmodule

bind gauge_needle_slew_limiter gnsl_checker u_gnsl_checker (.*);

// ===== bench/gauge_needle_monitor.sv =====
// Monitor for the gauge needle slew limiter: predicts every result and compares it.
module gauge_needle_monitor
  import gnsl_pkg::*;
#(
  parameter int unsigned STEP_INTERVAL_MS = 5,
  parameter int unsigned STEP_DEGREES     = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [1:0]                kind_i,
  input  logic signed [VALUE_W-1:0] operand_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [ANGLE_W-1:0] needle_angle_i,
  input  logic                      adjusting_i,
  input  logic                      stepped_i,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic [CFG_ADDR_W-1:0]     paddr_i,
  input  logic [31:0]               pwdata_i,
  input  logic                      pready_i,
  output int                        outstanding_o,
  output int                        mismatches_o
);

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               adjusting;
    logic               stepped;
  } needle_report_t;

  // predicted needle state and range registers
  logic signed [ANGLE_W-1:0]     needle;
  logic signed [ANGLE_W-1:0]     target;
  logic [COUNT_W-1:0]            idle_ms;
  logic signed [CFG_ANGLE_W-1:0] lo_angle;
  logic signed [CFG_ANGLE_W-1:0] hi_angle;
  logic signed [VALUE_W-1:0]     lo_value;
  logic signed [VALUE_W-1:0]     hi_value;

  needle_report_t reports_q[$];
  int             mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  task automatic flag_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic longint map_span(input longint x, input longint in_lo,
                                      input longint in_hi, input longint out_lo,
                                      input longint out_hi);
    longint den;
    den = in_hi - in_lo;
    if (den == 0) return out_lo;
    return (x - in_lo) * (out_hi - out_lo) / den + out_lo;
  endfunction

  // wrap to 16 bits, then clamp above at the ceiling
  function automatic logic signed [ANGLE_W-1:0] to_target(input longint raw);
    logic signed [ANGLE_W-1:0] wrapped;
    wrapped = raw[ANGLE_W-1:0];
    if (wrapped > ANGLE_CEILING) wrapped = ANGLE_CEILING;
    return wrapped;
  endfunction

  function automatic needle_report_t advance_needle(input kind_e kind,
                                                    input logic signed [VALUE_W-1:0] operand);
    needle_report_t rep;
    int             pos;
    rep.stepped = 1'b0;
    case (kind)
      KIND_TICK: begin
        if (idle_ms != COUNT_MAX) idle_ms++;
        if (needle != target && idle_ms > STEP_INTERVAL_MS) begin
          pos = needle;
          if (needle < target) begin
            pos = pos + int'(STEP_DEGREES);
            if (pos >= target) pos = target;
          end else begin
            pos = pos - int'(STEP_DEGREES);
            if (pos <= target) pos = target;
          end
          needle      = ANGLE_W'(pos);
          idle_ms     = '0;
          rep.stepped = 1'b1;
        end
      end
      KIND_VALUE: begin
        target = to_target(map_span(longint'(operand), longint'(lo_value),
                                    longint'(hi_value), longint'(lo_angle),
                                    longint'(hi_angle)));
      end
      KIND_PERCENT: begin
        target = to_target(map_span(longint'(operand[7:0]), 0, PERCENT_FULL,
                                    longint'(lo_angle), longint'(hi_angle)));
      end
      default: begin
        target = to_target(longint'(operand));
      end
    endcase
    rep.angle     = needle;
    rep.adjusting = (needle != target);
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    needle_report_t want;
    if (!rst_ni) begin
      needle   = '0;
      target   = '0;
      idle_ms  = '0;
      lo_angle = '0;
      hi_angle = CFG_ANGLE_W'(359);
      lo_value = '0;
      hi_value = '0;
      reports_q.delete();
      outstanding_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[CFG_ADDR_W-1:2]))
          REG_MIN_ANGLE: lo_angle = pwdata_i[CFG_ANGLE_W-1:0];
          REG_MAX_ANGLE: hi_angle = pwdata_i[CFG_ANGLE_W-1:0];
          REG_MIN_VALUE: lo_value = pwdata_i[VALUE_W-1:0];
          default:       hi_value = pwdata_i[VALUE_W-1:0];
        endcase
      end
      if (in_valid_i && !in_stall_i)
        reports_q.push_back(advance_needle(kind_e'(kind_i), operand_i));
      if (out_valid_i && !out_stall_i) begin
        if (reports_q.size() == 0) begin
          flag_mismatch($sformatf("result angle %0d with no item pending",
                                  needle_angle_i));
        end else begin
          want = reports_q.pop_front();
          if (needle_angle_i !== want.angle)
            flag_mismatch($sformatf("needle_angle got %0d want %0d",
                                    needle_angle_i, $signed(want.angle)));
          if (adjusting_i !== want.adjusting)
            flag_mismatch($sformatf("adjusting got %b want %b",
                                    adjusting_i, want.adjusting));
          if (stepped_i !== want.stepped)
            flag_mismatch($sformatf("stepped got %b want %b",
                                    stepped_i, want.stepped));
        end
      end
      outstanding_o <= reports_q.size();
    end
  end

endmodule

// ===== bench/tb_gauge_needle_slew_limiter.sv =====
// Testbench top for the gauge needle slew limiter: stimulus, clock, reset, verdict.
module tb_gauge_needle_slew_limiter;
  import gnsl_pkg::*;

  localparam int unsigned STEP_INTERVAL_MS = 5;
  localparam int unsigned STEP_DEGREES     = 1;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                kind_i      = KIND_TICK;
  logic signed [VALUE_W-1:0] operand_i   = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [ANGLE_W-1:0] needle_angle_o;
  logic                      adjusting_o;
  logic                      stepped_o;
  logic                      psel        = 1'b0;
  logic                      penable     = 1'b0;
  logic                      pwrite      = 1'b0;
  logic [CFG_ADDR_W-1:0]     paddr       = '0;
  logic [31:0]               pwdata      = '0;
  logic [31:0]               prdata;
  logic                      pready;

  int outstanding;
  int mismatches;

  // calm: no input gaps and no output stalls while set
  bit calm = 1'b0;
  // value range of the current phase, used to aim set value operands
  int value_lo = 0;
  int value_hi = 0;

  gauge_needle_slew_limiter #(
    .STEP_INTERVAL_MS(STEP_INTERVAL_MS),
    .STEP_DEGREES    (STEP_DEGREES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .operand_i     (operand_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .needle_angle_o(needle_angle_o),
    .adjusting_o   (adjusting_o),
    .stepped_o     (stepped_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  gauge_needle_monitor #(
    .STEP_INTERVAL_MS(STEP_INTERVAL_MS),
    .STEP_DEGREES    (STEP_DEGREES)
  ) monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .kind_i        (kind_i),
    .operand_i     (operand_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .needle_angle_i(needle_angle_o),
    .adjusting_i   (adjusting_o),
    .stepped_i     (stepped_o),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  always #5 clk_i = ~clk_i;

  // Receiver side: stall about a third of the cycles, independent of valid.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 33);
  end

  // One input transfer. Called at a rising edge; returns at the accepting edge
  // with valid still high, so back-to-back items keep valid up without a dip.
  task automatic push_item(input kind_e kind, input logic [VALUE_W-1:0] operand);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    operand_i  <= operand;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every predicted result has been taken. The
  // monitor's count is registered, hence the edge before the first look.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle. psel is left high so the next
  // write's setup follows without a second assignment in the same step.
  task automatic write_reg(input reg_idx_e idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  // Load all four range registers while the block is idle.
  task automatic set_ranges(input int angle_lo, input int angle_hi,
                            input int val_lo, input int val_hi);
    wait_drained();
    write_reg(REG_MIN_ANGLE, angle_lo);
    write_reg(REG_MAX_ANGLE, angle_hi);
    write_reg(REG_MIN_VALUE, val_lo);
    write_reg(REG_MAX_VALUE, val_hi);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    value_lo  = val_lo;
    value_hi  = val_hi;
  endtask

  function automatic logic [VALUE_W-1:0] pick_operand(input kind_e kind);
    logic [VALUE_W-1:0] op;
    int                 roll;
    int                 span_lo;
    int                 span_hi;
    op      = VALUE_W'($urandom);
    roll    = $urandom_range(99);
    span_lo = (value_lo < value_hi) ? value_lo : value_hi;
    span_hi = (value_lo < value_hi) ? value_hi : value_lo;
    case (kind)
      KIND_VALUE: begin
        if (roll < 40) begin
          op = VALUE_W'(span_lo + int'($urandom_range(span_hi - span_lo)));
        end else if (roll < 60) begin
          case ($urandom_range(3))
            0:       op = 16'h8000;
            1:       op = 16'h7FFF;
            2:       op = 16'h0000;
            default: op = 16'hFFFF;
          endcase
        end
      end
      KIND_PERCENT: begin
        // mostly sane percents; the upper byte stays random since it is ignored
        if (roll < 80) op[7:0] = 8'($urandom_range(110));
      end
      KIND_ANGLE: begin
        // near-zero targets let the needle actually arrive and rest
        if (roll < 50)      op = VALUE_W'(int'($urandom_range(20)) - 10);
        else if (roll < 80) op = VALUE_W'(int'($urandom_range(800)) - 400);
      end
      default: ;
    endcase
    return op;
  endfunction

  // Mostly ticks, as in use; a quarter are set commands of random kind.
  task automatic run_mix(input int count);
    kind_e kind;
    for (int n = 0; n < count; n++) begin
      kind = ($urandom_range(99) < 75) ? KIND_TICK : kind_e'($urandom_range(1, 3));
      push_item(kind, pick_operand(kind));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset ranges (angles 0..359, empty value range).
    push_item(KIND_TICK, 16'h0000);
    push_item(KIND_ANGLE, 16'h0002);
    // counter must exceed the interval before the first step
    repeat (6) push_item(KIND_TICK, 16'h0000);
    push_item(KIND_ANGLE, 16'h7FFF);     // clamped to the ceiling
    push_item(KIND_ANGLE, 16'h8000);     // most negative target, no lower clamp
    push_item(KIND_PERCENT, 16'hFF00);   // zero percent, upper byte ignored
    push_item(KIND_PERCENT, 16'h0064);   // hundred percent
    push_item(KIND_PERCENT, 16'h00FF);   // extrapolates past max, then clamped
    push_item(KIND_PERCENT, 16'h8032);   // fifty percent, truncating divide
    push_item(KIND_VALUE, 16'h8000);     // empty value range gives min angle
    push_item(KIND_VALUE, 16'h7FFF);
    push_item(KIND_ANGLE, 16'h0001);     // target equals the needle: at rest
    push_item(KIND_TICK, 16'hFFFF);      // operand ignored on a tick
    push_item(KIND_TICK, 16'h5A5A);

    // Long rest: the tick counter runs into saturation while at target.
    repeat (270) push_item(KIND_TICK, VALUE_W'($urandom));

    // Random phases, each with its own range setting.
    set_ranges(-359, 359, -32768, 32767);
    run_mix(110);
    set_ranges(359, -359, 32767, -32768);   // reversed ranges
    run_mix(110);
    set_ranges(0, 359, 0, 100);
    calm = 1'b1;                              // stretch with no gaps or stalls
    run_mix(110);
    calm = 1'b0;
    set_ranges(-512, 511, 5, 5);             // 10-bit extremes, empty value range
    run_mix(110);
    set_ranges(100, 100, -1, 0);             // flat angle map, one-step value span
    run_mix(110);
    repeat (2) begin
      set_ranges(int'($urandom_range(1023)) - 512, int'($urandom_range(1023)) - 512,
                 int'($urandom_range(65535)) - 32768,
                 int'($urandom_range(65535)) - 32768);
      run_mix(110);
    end

    // Drain, then leave room for a stray late result.
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_gauge_needle_slew_limiter passed");
    end else begin
      $display("tb_gauge_needle_slew_limiter failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of about 1100 items.
  initial begin
    #5_000_000;
    $display("tb_gauge_needle_slew_limiter failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/gnsl_pkg.sv
sv/gnsl_div.sv
sv/gauge_needle_slew_limiter.sv
sv/gnsl_checker.sv
bench/gauge_needle_monitor.sv
bench/tb_gauge_needle_slew_limiter.sv
